### hw/rtl/sirc_pkg.sv
// Shared types and constants for the signed integer to radix digits converter.
// Used by sirc_front, sirc_queue, sirc_back and the top level.
`default_nettype none

package sirc_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int IN_W        = 32;
	localparam int MAX_RADIX   = 16;
	localparam int NCHARS      = 16;
	localparam int CHAR_W      = 8;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int RADIX_W     = 5;
	localparam int DIG_W       = $clog2(MAX_RADIX);

	// long division works on the magnitude one chunk per cycle
	localparam int CHUNK   = 8;
	localparam int NCHUNK  = (VALUE_WIDTH + CHUNK - 1) / CHUNK;
	localparam int MAG_W   = NCHUNK * CHUNK;
	localparam int CIDX_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int NDIG_W  = $clog2(VALUE_WIDTH + 1);
	localparam int STK_W   = VALUE_WIDTH * DIG_W;

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = 1;
	localparam int QCNT_W  = 2;

	localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'd0;
	localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'd43;
	localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;

	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd2;

	typedef struct packed {
		logic [NCHARS-1:0][CHAR_W-1:0] chars;
		logic [RADIX_W-1:0]            radix;
	} alpha_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} q_entry_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_SIGN,
		B_EMIT
	} back_state_t;

endpackage

`default_nettype wire

### hw/rtl/sirc_queue.sv
// Two-entry queue between the front and back of the converter.
// Depends on sirc_pkg for the entry type.
`default_nettype none

module sirc_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr,
	input  wire sirc_pkg::q_entry_t din,
	output logic                    full,
	input  wire logic               rd,
	output sirc_pkg::q_entry_t      dout,
	output logic                    empty
);
	import sirc_pkg::*;

	q_entry_t          mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full  = (cnt_q == QCNT_W'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= wptr_q + 1'b1;
			if (do_rd)
				rptr_q <= rptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= din;
	end

endmodule

`default_nettype wire

### hw/rtl/sirc_front.sv
// Front end: input register, alphabet check, sign split and magnitude.
// Depends on sirc_pkg; feeds sirc_queue.
`default_nettype none

module sirc_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire logic [sirc_pkg::IN_W-1:0] value,
	output logic                        full,
	input  wire sirc_pkg::alpha_t       alpha,
	input  wire logic                   q_full,
	output logic                        q_wr,
	output sirc_pkg::q_entry_t          q_din
);
	import sirc_pkg::*;

	logic [VALUE_WIDTH-1:0] val_s1;
	logic                   vld_s1;
	logic                   alpha_ok_q;
	logic                   alpha_ok;
	logic                   advance;
	logic                   take;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;

	// alphabet check, registered once per cycle from the config registers
	always_comb begin
		alpha_ok = (alpha.radix >= RADIX_W'(2)) && (alpha.radix <= RADIX_W'(MAX_RADIX));
		for (int i = 0; i < MAX_RADIX; i++) begin
			if (RADIX_W'(i) < alpha.radix) begin
				if (alpha.chars[i] == NUL_CHAR || alpha.chars[i] == PLUS_CHAR ||
				    alpha.chars[i] == MINUS_CHAR)
					alpha_ok = 1'b0;
				for (int j = i + 1; j < MAX_RADIX; j++) begin
					if (RADIX_W'(j) < alpha.radix && alpha.chars[i] == alpha.chars[j])
						alpha_ok = 1'b0;
				end
			end
		end
	end

	// an item with a bad alphabet is dropped without output
	assign advance = vld_s1 && (!alpha_ok_q || !q_full);
	assign full    = vld_s1 && !advance;
	assign take    = push && !full;
	assign q_wr    = vld_s1 && alpha_ok_q && !q_full;

	assign neg       = val_s1[VALUE_WIDTH-1];
	assign mag       = neg ? (~val_s1 + 1'b1) : val_s1;
	assign q_din.neg = neg;
	assign q_din.mag = MAG_W'(mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			alpha_ok_q <= 1'b0;
		end else begin
			alpha_ok_q <= alpha_ok;
			if (take)
				vld_s1 <= 1'b1;
			else if (advance)
				vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			val_s1 <= value[VALUE_WIDTH-1:0];
	end

endmodule

`default_nettype wire

### hw/rtl/sirc_back.sv
// Back end: chunk-serial division by the radix, digit stack, character output.
// Depends on sirc_pkg; reads from sirc_queue.
`default_nettype none

module sirc_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire sirc_pkg::alpha_t           alpha,
	input  wire logic                       q_empty,
	input  wire sirc_pkg::q_entry_t         q_dout,
	output logic                            q_rd,
	output logic                            empty,
	input  wire logic                       pop,
	output logic [sirc_pkg::CHAR_W-1:0]     character,
	output logic                            last
);
	import sirc_pkg::*;

	back_state_t         state_q;
	back_state_t         state_nx;
	logic [MAG_W-1:0]    mag_q;
	logic [CIDX_W-1:0]   idx_q;
	logic [DIG_W-1:0]    rem_q;
	logic                neg_q;
	logic [STK_W-1:0]    stack_q;
	logic [NDIG_W-1:0]   ndig_q;
	logic                ovld_q;
	logic [CHAR_W-1:0]   ochar_q;
	logic                olast_q;

	logic [CHUNK-1:0]    cur_chunk;
	logic [CHUNK-1:0]    q_chunk;
	logic [DIG_W-1:0]    rem_new;
	logic [RADIX_W-1:0]  trial;
	logic [MAG_W-1:0]    mag_next;
	logic                mag_zero;
	logic                ld_ok;
	logic                out_ld;
	logic [CHAR_W-1:0]   out_char;
	logic                out_last;
	logic                push_dig;
	logic                pop_dig;

	function automatic logic [CIDX_W-1:0] top_chunk(input logic [MAG_W-1:0] m);
		logic [CIDX_W-1:0] t;
		t = '0;
		for (int c = 0; c < NCHUNK; c++) begin
			if (|m[c*CHUNK +: CHUNK])
				t = CIDX_W'(c);
		end
		return t;
	endfunction

	// one chunk of restoring division per cycle
	always_comb begin
		cur_chunk = mag_q[idx_q*CHUNK +: CHUNK];
		q_chunk   = '0;
		rem_new   = rem_q;
		trial     = '0;
		for (int k = CHUNK - 1; k >= 0; k--) begin
			trial = RADIX_W'({rem_new, cur_chunk[k]});
			if (trial >= alpha.radix) begin
				q_chunk[k] = 1'b1;
				trial      = trial - alpha.radix;
			end
			rem_new = trial[DIG_W-1:0];
		end
		mag_next = mag_q;
		mag_next[idx_q*CHUNK +: CHUNK] = q_chunk;
	end

	assign mag_zero = (mag_next == '0);
	assign ld_ok    = !ovld_q || pop;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty)
					state_nx = B_DIV;
			end
			B_DIV: begin
				if (idx_q == '0 && mag_zero)
					state_nx = neg_q ? B_SIGN : B_EMIT;
			end
			B_SIGN: begin
				if (ld_ok)
					state_nx = B_EMIT;
			end
			B_EMIT: begin
				if (ld_ok && ndig_q == NDIG_W'(1))
					state_nx = B_IDLE;
			end
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		q_rd     = 1'b0;
		out_ld   = 1'b0;
		out_char = alpha.chars[stack_q[DIG_W-1:0]];
		out_last = 1'b0;
		push_dig = 1'b0;
		pop_dig  = 1'b0;
		unique case (state_q)
			B_IDLE: q_rd = !q_empty;
			B_DIV:  push_dig = (idx_q == '0);
			B_SIGN: begin
				out_ld   = ld_ok;
				out_char = MINUS_CHAR;
			end
			B_EMIT: begin
				out_ld   = ld_ok;
				pop_dig  = ld_ok;
				out_last = (ndig_q == NDIG_W'(1));
			end
			default: q_rd = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ovld_q  <= 1'b0;
			ndig_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (out_ld)
				ovld_q <= 1'b1;
			else if (pop)
				ovld_q <= 1'b0;
			if (q_rd)
				ndig_q <= '0;
			else if (push_dig)
				ndig_q <= ndig_q + 1'b1;
			else if (pop_dig)
				ndig_q <= ndig_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			mag_q <= q_dout.mag;
			neg_q <= q_dout.neg;
			idx_q <= top_chunk(q_dout.mag);
			rem_q <= '0;
		end else if (state_q == B_DIV) begin
			mag_q <= mag_next;
			if (idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
				rem_q <= rem_new;
			end else begin
				idx_q <= top_chunk(mag_next);
				rem_q <= '0;
			end
		end
		if (push_dig)
			stack_q <= {stack_q[STK_W-DIG_W-1:0], rem_new};
		else if (pop_dig)
			stack_q <= stack_q >> DIG_W;
		if (out_ld) begin
			ochar_q <= out_char;
			olast_q <= out_last;
		end
	end

	assign empty     = !ovld_q;
	assign character = ochar_q;
	assign last      = olast_q;

endmodule

`default_nettype wire

### hw/rtl/signed_integer_to_custom_radix_digits.sv
// Top level: signed integer to characters in a configured digit alphabet.
// Instantiates sirc_front, sirc_queue and sirc_back; depends on sirc_pkg.
//
//  channel   handshake          payload
//  input     push / full        value[31:0] (signed)
//  result    empty / pop        character[7:0], last
//  config    cfg_we             cfg_index[1:0], cfg_data[63:0]
//
// The back divides the magnitude by the radix one 8-bit chunk per cycle, starting at
// the highest nonzero chunk; each full pass yields one digit, least significant first.
// After the last pass it emits a minus sign if the value is negative, then the digits
// most significant first, stalling while the output holds a character not yet popped.
// Front and back stall independently; a two-entry queue sits between them.
// Reset clears the config registers (alphabet invalid) and all control state.
`default_nettype none

module signed_integer_to_custom_radix_digits (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic signed [sirc_pkg::IN_W-1:0] value,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [sirc_pkg::CHAR_W-1:0]           character,
	output logic                                  last,
	input  wire logic                             cfg_we,
	input  wire logic [sirc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sirc_pkg::CFG_W-1:0]       cfg_data
);
	import sirc_pkg::*;

	logic [CFG_W-1:0]   chars_lo_q;
	logic [CFG_W-1:0]   chars_hi_q;
	logic [RADIX_W-1:0] radix_q;
	alpha_t             alpha;
	logic               q_full;
	logic               q_empty;
	logic               q_wr;
	logic               q_rd;
	q_entry_t           q_din;
	q_entry_t           q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_lo_q <= '0;
			chars_hi_q <= '0;
			radix_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHARS_LOW:  chars_lo_q <= cfg_data;
				CFG_CHARS_HIGH: chars_hi_q <= cfg_data;
				CFG_RADIX:      radix_q    <= cfg_data[RADIX_W-1:0];
				default: ;
			endcase
		end
	end

	assign alpha.chars = {chars_hi_q, chars_lo_q};
	assign alpha.radix = radix_q;

	sirc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.value  (value),
		.full   (full),
		.alpha  (alpha),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_din  (q_din)
	);

	sirc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.din    (q_din),
		.full   (q_full),
		.rd     (q_rd),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	sirc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.alpha     (alpha),
		.q_empty   (q_empty),
		.q_dout    (q_dout),
		.q_rd      (q_rd),
		.empty     (empty),
		.pop       (pop),
		.character (character),
		.last      (last)
	);

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue both full and empty");

	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (character != NUL_CHAR))
		else $error("zero byte on result");

	a_last_not_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> (character != MINUS_CHAR))
		else $error("run ends with minus sign");

	a_wr_only_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_full)
		else $error("queue write while full");

endmodule

`default_nettype wire

### tb/sv/signed_integer_to_custom_radix_digits_test.sv
// Testbench for signed_integer_to_custom_radix_digits: a directed table, then random
// alphabets and values, every character checked vs. typed text or in-bench predictor.
// Depends on sirc_pkg and the top level RTL only.
`timescale 1ns / 100ps

module signed_integer_to_custom_radix_digits_test;

	localparam logic [sirc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [63:0] DEC_LOW   = 64'h3736353433323130;	// "0".."7"
	localparam logic [63:0] HEX_HIGH  = 64'h4645444342413938;	// "8".."F"
	localparam int SETTLE_CYCLES = 500;
	localparam int MAX_CYCLES    = 1000000;
	localparam int RANDOM_ITEMS  = 120;
	localparam int CALM_AFTER    = 95;

	typedef struct packed {
		logic [sirc_pkg::CHAR_W-1:0] ch;
		logic                        fin;
	} char_t;

	typedef struct {
		bit                              is_cfg;
		logic [sirc_pkg::CFG_IDX_W-1:0]  idx;
		logic [sirc_pkg::CFG_W-1:0]      data;
		logic [sirc_pkg::IN_W-1:0]       val;
		bit                              typed;
		string                           text;
	} script_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                push = 1'b0;
	logic                                full;
	logic signed [sirc_pkg::IN_W-1:0]    value = '0;
	logic                                empty;
	logic                                pop = 1'b0;
	logic [sirc_pkg::CHAR_W-1:0]         character;
	logic                                last;
	logic                                cfg_we = 1'b0;
	logic [sirc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [sirc_pkg::CFG_W-1:0]          cfg_data = '0;

	// shadow of the configuration registers
	logic [63:0] alpha_lo = '0;
	logic [63:0] alpha_hi = '0;
	logic [4:0]  alpha_radix = '0;

	char_t       pending_chars[$];
	script_row_t script[$];

	int          odds_pool[3] = '{0, 10, 35};
	int          gap_odds = 0;
	int          stall_odds = 0;
	int          stall_left = 0;
	bit          calm = 1'b0;
	bit          dirty = 1'b0;
	int unsigned cycle_count = 0;
	int          mismatches = 0;
	int          chars_checked = 0;
	int          items_sent = 0;
	int          alphabets = 0;

	signed_integer_to_custom_radix_digits uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.value    (value),
		.empty    (empty),
		.pop      (pop),
		.character(character),
		.last     (last),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == MAX_CYCLES) begin
			$display("Timeout after %0d cycles, %0d characters outstanding", cycle_count,
				pending_chars.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] glyph(input int d);
		return (d < 8) ? alpha_lo[8*d +: 8] : alpha_hi[8*(d-8) +: 8];
	endfunction

	function automatic bit alphabet_usable();
		int n;
		n = int'(alpha_radix);
		if (n < 2 || n > sirc_pkg::MAX_RADIX)
			return 1'b0;
		for (int i = 0; i < n; i++) begin
			if (glyph(i) == sirc_pkg::NUL_CHAR || glyph(i) == sirc_pkg::PLUS_CHAR ||
			    glyph(i) == sirc_pkg::MINUS_CHAR)
				return 1'b0;
			for (int j = i + 1; j < n; j++)
				if (glyph(j) == glyph(i))
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// expected characters for one accepted value
	function automatic void convert_value(input logic [31:0] v);
		logic        neg;
		logic [31:0] mag;
		logic [31:0] base;
		int          digs[$];
		if (!alphabet_usable())
			return;
		base = 32'(alpha_radix);
		neg = v[31];
		mag = neg ? -v : v;
		do begin
			digs.push_back(int'(mag % base));
			mag = mag / base;
		end while (mag != 0);
		if (neg)
			pending_chars.push_back('{sirc_pkg::MINUS_CHAR, 1'b0});
		for (int k = digs.size() - 1; k >= 0; k--)
			pending_chars.push_back('{glyph(digs[k]), k == 0});
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_char(input logic [7:0] ch, input logic fin);
		char_t want;
		if (pending_chars.size() == 0) begin
			note_mismatch($sformatf("unexpected character %h last %b", ch, fin));
			return;
		end
		want = pending_chars.pop_front();
		chars_checked++;
		if (ch !== want.ch || fin !== want.fin)
			note_mismatch($sformatf("character %h last %b, expected %h last %b",
				ch, fin, want.ch, want.fin));
	endtask

	always @(posedge clk)
		if (arst_n && pop && !empty)
			check_char(character, last);

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < stall_odds) begin
			stall_left <= $urandom_range(0, 11);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic send_value(input logic [31:0] v);
		int gap;
		if (!calm && $urandom_range(0, 99) < gap_odds) begin
			gap = $urandom_range(1, 12);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		value <= v;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
		dirty = 1'b1;
	endtask

	// drain all results, then give a dropped item time to leave the pipeline
	task automatic settle();
		push <= 1'b0;
		if (dirty) begin
			while (pending_chars.size() != 0)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
			dirty = 1'b0;
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			sirc_pkg::CFG_CHARS_LOW:  alpha_lo = data;
			sirc_pkg::CFG_CHARS_HIGH: alpha_hi = data;
			sirc_pkg::CFG_RADIX:      alpha_radix = data[4:0];
			default: ;
		endcase
	endtask

	task automatic add_cfg(input logic [1:0] idx, input logic [63:0] data);
		script.push_back('{1'b1, idx, data, 32'd0, 1'b0, ""});
	endtask

	task automatic add_item(input logic [31:0] v, input bit typed = 1'b0,
			input string text = "");
		script.push_back('{1'b0, 2'd0, 64'd0, v, typed, text});
	endtask

	initial begin : stimulus
		logic [7:0]  glyphs[16];
		bit          used[256];
		logic [7:0]  c;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  rdx;
		logic [31:0] v;
		longint      p;
		int          r;
		int          n;
		int          pos;
		int          other;
		int          valid_items;
		bit          broken;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the alphabet is invalid
		add_item(32'd5, 1'b1, "");
		add_item(32'hFFFF_FFFF, 1'b1, "");
		add_cfg(sirc_pkg::CFG_CHARS_LOW, DEC_LOW);
		add_cfg(sirc_pkg::CFG_CHARS_HIGH, HEX_HIGH);
		add_cfg(sirc_pkg::CFG_RADIX, 64'd10);
		add_item(32'd0, 1'b1, "0");
		add_item(32'h7FFF_FFFF, 1'b1, "2147483647");
		add_item(32'h8000_0000, 1'b1, "-2147483648");
		add_item(32'hFFFF_FFFF, 1'b1, "-1");
		add_item(32'd10, 1'b1, "10");
		add_cfg(sirc_pkg::CFG_RADIX, 64'd16);
		add_item(32'h7FFF_FFFF, 1'b1, "7FFFFFFF");
		add_item(32'h8000_0000, 1'b1, "-80000000");
		add_item(32'hDEAD_BEEF, 1'b1, "-21524111");
		add_item(32'h0000_00FF, 1'b1, "FF");
		add_cfg(sirc_pkg::CFG_RADIX, 64'd2);
		add_item(32'h8000_0000);
		add_item(32'd1, 1'b1, "1");
		add_item(32'd0, 1'b1, "0");
		add_item(32'h7FFF_FFFF);
		// characters past the radix are ignored, even zero, plus, minus and repeats
		add_cfg(sirc_pkg::CFG_CHARS_HIGH, 64'h0000_2D2B_3030_3030);
		add_cfg(sirc_pkg::CFG_RADIX, 64'd8);
		add_item(-32'sd8, 1'b1, "-10");
		// minus as the very last digit in use
		add_cfg(sirc_pkg::CFG_CHARS_HIGH, 64'h2D45_4443_4241_3938);
		add_cfg(sirc_pkg::CFG_RADIX, 64'd16);
		add_item(32'd1, 1'b1, "");
		add_cfg(sirc_pkg::CFG_CHARS_HIGH, HEX_HIGH);
		add_cfg(sirc_pkg::CFG_CHARS_LOW, 64'h3736_3534_3332_3030);
		add_item(32'd1, 1'b1, "");
		add_cfg(sirc_pkg::CFG_CHARS_LOW, 64'h3736_3534_3332_312B);
		add_item(32'd7, 1'b1, "");
		add_cfg(sirc_pkg::CFG_CHARS_LOW, 64'h3736_3500_3332_3130);
		add_item(32'd7, 1'b1, "");
		add_cfg(sirc_pkg::CFG_CHARS_LOW, DEC_LOW);
		add_cfg(sirc_pkg::CFG_RADIX, 64'd1);
		add_item(32'd0, 1'b1, "");
		add_cfg(sirc_pkg::CFG_RADIX, 64'd17);
		add_item(32'd0, 1'b1, "");
		add_cfg(sirc_pkg::CFG_RADIX, 64'd31);
		add_item(32'd0, 1'b1, "");
		// unused index is ignored; only the low five bits of the radix count
		add_cfg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		add_cfg(sirc_pkg::CFG_RADIX, 64'hFFFF_FFFF_FFFF_FFE3);
		add_item(-32'sd5, 1'b1, "-12");

		gap_odds = 20;
		stall_odds = 20;
		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				settle();
				write_reg(script[i].idx, script[i].data);
				alphabets++;
			end else begin
				send_value(script[i].val);
				if (script[i].typed) begin
					for (int k = 0; k < script[i].text.len(); k++)
						pending_chars.push_back('{script[i].text[k],
							k == script[i].text.len() - 1});
				end else begin
					convert_value(script[i].val);
				end
			end
		end

		valid_items = 0;
		while (valid_items < RANDOM_ITEMS) begin
			calm = (valid_items >= CALM_AFTER);
			gap_odds = calm ? 0 : odds_pool[$urandom_range(0, 2)];
			stall_odds = calm ? 0 : odds_pool[$urandom_range(0, 2)];

			case ($urandom_range(0, 3))
				0:       r = 2;
				1:       r = 16;
				default: r = $urandom_range(2, 16);
			endcase
			used = '{default: 1'b0};
			for (int d = 0; d < 16; d++) begin
				do
					c = 8'($urandom_range(1, 255));
				while (c == sirc_pkg::PLUS_CHAR || c == sirc_pkg::MINUS_CHAR || used[c]);
				used[c] = 1'b1;
				glyphs[d] = c;
			end
			if ($urandom_range(0, 1))
				for (int d = r; d < 16; d++)
					glyphs[d] = 8'($urandom_range(0, 255));
			rdx = 5'(r);
			broken = !calm && ($urandom_range(0, 4) == 0);
			if (broken) begin
				pos = $urandom_range(0, r - 1);
				case ($urandom_range(0, 4))
					0: rdx = ($urandom_range(0, 1)) ? 5'($urandom_range(0, 1)) :
						5'($urandom_range(17, 31));
					1: glyphs[pos] = sirc_pkg::NUL_CHAR;
					2: glyphs[pos] = sirc_pkg::PLUS_CHAR;
					3: glyphs[pos] = sirc_pkg::MINUS_CHAR;
					default: begin
						do
							other = $urandom_range(0, r - 1);
						while (other == pos);
						glyphs[pos] = glyphs[other];
					end
				endcase
			end
			for (int d = 0; d < 8; d++) begin
				lo[8*d +: 8] = glyphs[d];
				hi[8*d +: 8] = glyphs[d + 8];
			end

			settle();
			write_reg(sirc_pkg::CFG_CHARS_LOW, lo);
			write_reg(sirc_pkg::CFG_CHARS_HIGH, hi);
			write_reg(sirc_pkg::CFG_RADIX, {$urandom, 27'($urandom), rdx});
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_UNUSED, {$urandom, $urandom});
			alphabets++;

			n = broken ? $urandom_range(2, 5) : $urandom_range(6, 16);
			repeat (n) begin
				case ($urandom_range(0, 9))
					0: v = 32'($urandom_range(0, 80)) - 32'd40;
					1: case ($urandom_range(0, 3))
						0:       v = 32'h8000_0000;
						1:       v = 32'h7FFF_FFFF;
						2:       v = 32'h0;
						default: v = 32'hFFFF_FFFF;
					endcase
					2, 3: begin
						// near a power of the radix
						p = 1;
						repeat ($urandom_range(0, 31))
							if (p * r <= 64'h7FFF_FFFF)
								p = p * r;
						v = 32'(p) + 32'($urandom_range(0, 2)) - 32'd1;
						if ($urandom_range(0, 1))
							v = -v;
					end
					4, 5: begin
						v = $urandom >> $urandom_range(0, 31);
						if ($urandom_range(0, 1))
							v = -v;
					end
					default: v = $urandom;
				endcase
				send_value(v);
				convert_value(v);
				if (alphabet_usable())
					valid_items++;
			end
		end

		settle();
		if (pending_chars.size() != 0) begin
			$display("%0d expected characters never arrived", pending_chars.size());
			mismatches += pending_chars.size();
		end
		$display("Converted %0d values under %0d alphabet settings, radix 2 to 16 and invalid;",
			items_sent, alphabets);
		$display("%0d characters checked, %0d mismatches.", chars_checked, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/sirc_pkg.sv
hw/rtl/sirc_queue.sv
hw/rtl/sirc_front.sv
hw/rtl/sirc_back.sv
hw/rtl/signed_integer_to_custom_radix_digits.sv
tb/sv/signed_integer_to_custom_radix_digits_test.sv
